>>> rtl/ap2d_pkg.sv
// ----------------------------------------------------------------------------
// ap2d_pkg
// Shared constants for the 2-D average pooling block.
// ----------------------------------------------------------------------------
package ap2d_pkg;

  localparam int MaxWidthDefault = 1024;
  localparam int MaxPoolDefault  = 8;
  localparam int HeightLimit     = 1024;

  localparam logic [1:0] RegPoolSize    = 2'd0;
  localparam logic [1:0] RegStride      = 2'd1;
  localparam logic [1:0] RegImageHeight = 2'd2;
  localparam logic [1:0] RegImageWidth  = 2'd3;

  localparam logic [3:0]  PoolReset   = 4'd2;
  localparam logic [3:0]  StrideReset = 4'd2;
  localparam logic [10:0] HeightReset = 11'd32;
  localparam logic [10:0] WidthReset  = 11'd32;

endpackage

>>> rtl/ap2d_ram.sv
// ----------------------------------------------------------------------------
// ap2d_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ap2d_ram #(
  parameter int Width = 16,
  parameter int Depth = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/average_pool_2d.sv
// ----------------------------------------------------------------------------
// average_pool_2d
// Streaming 2-D average pooling of one Q8.8 channel image with a line store.
// ----------------------------------------------------------------------------
//  channel   signals                                 role
//  in        pixel_valid / pixel_ready / pixel        one pixel request
//  out       result_valid / result_ready / average,   one pooled value
//            last_of_channel
//  cfg       cfg_we / cfg_index / cfg_data            register write
//
// Steps: a pixel that ends no emitted window is accepted and written.
// A pixel that ends a window is accepted and written, then the window is read
// from the line store one entry a cycle, with a final step to collect the last
// read (one RAM read port sets this), then a 24-step restoring divide by P*P
// with setup and exit (default MAX_POOL), then the output load.
// Reset clears the position counters and registers; the line store
// has no reset. An output register holds the result, so the next pixel is
// taken while a result waits; the block stalls only when a new result is
// ready and the previous one has not been taken.
// ----------------------------------------------------------------------------
module average_pool_2d
  import ap2d_pkg::*;
#(
  parameter int MAX_WIDTH = MaxWidthDefault,
  parameter int MAX_POOL  = MaxPoolDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  logic signed [15:0] pixel,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [15:0] average,
  output logic               last_of_channel,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int SlotW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int AddrW = SlotW + ColW;
  localparam int PW    = $clog2(MAX_POOL + 1);
  localparam int AreaW = 2 * PW;
  localparam int SumW  = 16 + 2 * PW;
  localparam int RowW  = 11;

  typedef enum logic [2:0] {S_IDLE, S_WRITE, S_READ, S_DIV, S_OUT} state_t;
  state_t state;

  // configuration
  logic [3:0]  win_side, stride;
  logic [10:0] image_height, image_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_side     <= PoolReset;
      stride       <= StrideReset;
      image_height <= HeightReset;
      image_width  <= WidthReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegPoolSize:    win_side     <= cfg_data[3:0];
        RegStride:      stride       <= cfg_data[3:0];
        RegImageHeight: image_height <= cfg_data;
        RegImageWidth:  image_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective values
  logic [4:0]  p_eff;
  logic [3:0]  s_eff;
  logic [RowW:0] h_eff, w_eff;
  always_comb begin
    if (win_side == 4'd0) p_eff = 5'd1;
    else if ({1'b0, win_side} > 5'(MAX_POOL)) p_eff = 5'(MAX_POOL);
    else p_eff = {1'b0, win_side};
    s_eff = (stride == 4'd0) ? 4'd1 : stride;
    if (image_height == 11'd0) h_eff = 12'd1;
    else if ({1'b0, image_height} > 12'(HeightLimit)) h_eff = 12'(HeightLimit);
    else h_eff = {1'b0, image_height};
    if (image_width == 11'd0) w_eff = 12'd1;
    else if (32'(image_width) > MAX_WIDTH) w_eff = 12'(MAX_WIDTH);
    else w_eff = {1'b0, image_width};
  end

  // position and stride phase counters (phase = (pos+1-p) mod s when >= 0)
  logic [RowW-1:0] row_pos, col_pos;
  logic [3:0]      row_ph, col_ph;   // (pos + 1 - p) mod s tracked incrementally
  logic signed [RowW+1:0] rs_s, cs_s;
  logic            last_pixel, small_img, win_ok;

  assign rs_s = $signed({2'b0, row_pos}) + 13'sd1 - $signed({8'b0, p_eff});
  assign cs_s = $signed({2'b0, col_pos}) + 13'sd1 - $signed({8'b0, p_eff});
  assign last_pixel = ({1'b0, row_pos} + 12'd1 >= h_eff) && ({1'b0, col_pos} + 12'd1 >= w_eff);
  assign small_img  = (h_eff < 12'(p_eff)) || (w_eff < 12'(p_eff));
  assign win_ok = !rs_s[RowW+1] && !cs_s[RowW+1] && row_ph == 4'd0 && col_ph == 4'd0;

  // last window starts: ((h-p)/s)*s computed by repeated subtraction is long;
  // instead track: a window is last when no further window fits.
  logic last_win;
  assign last_win = (12'(rs_s[RowW:0]) + 12'(s_eff) + 12'(p_eff) > h_eff) &&
                    (12'(cs_s[RowW:0]) + 12'(s_eff) + 12'(p_eff) > w_eff);

  // line store
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [15:0]      ram_rdata;
  logic [15:0]      px_q;

  ap2d_ram #(.Width(16), .Depth(2 ** AddrW)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (px_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // window walk
  logic [SlotW-1:0] rslot0;
  logic [4:0]       wi, wj;
  logic [ColW-1:0]  cs_q;
  logic             rd_pend;
  logic signed [SumW-1:0] sum;
  logic             emit_zero, emit_last;
  logic [SumW-1:0]  rem_q, quo;
  logic [AreaW-1:0] area;
  logic [4:0]       dcnt;
  logic             neg;
  logic [SumW:0]    trial;
  logic [SlotW-1:0] rd_slot;

  assign rd_slot   = SlotW'(rslot0 + SlotW'(wi));
  assign ram_raddr = AddrW'({rd_slot, ColW'(cs_q + ColW'(wj))});
  assign ram_waddr = AddrW'({row_pos[SlotW-1:0], ColW'(col_pos)});
  assign ram_we    = (state == S_WRITE);
  assign pixel_ready = (state == S_IDLE) && !cfg_we;
  assign trial = {rem_q, quo[SumW-1]} - {{(SumW + 1 - AreaW){1'b0}}, area};

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      if (rst) begin
        state        <= S_IDLE;
        result_valid <= 1'b0;
      end
      row_pos <= '0;
      col_pos <= '0;
      row_ph  <= '0;
      col_ph  <= '0;
    end else begin
      if (result_valid && result_ready && state != S_OUT) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pixel_valid) begin
            px_q  <= pixel;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          emit_last <= last_win;
          emit_zero <= small_img;
          rslot0    <= rs_s[SlotW-1:0];
          cs_q      <= cs_s[ColW-1:0];
          wi <= '0; wj <= '0; rd_pend <= 1'b0; sum <= '0;
          area <= AreaW'(p_eff) * AreaW'(p_eff);
          if ((small_img && last_pixel) || (!small_img && win_ok)) state <= S_READ;
          else state <= S_IDLE;
          // advance position and phase
          if ({1'b0, col_pos} + 12'd1 >= w_eff) begin
            col_pos <= '0;
            col_ph  <= '0;
            if ({1'b0, row_pos} + 12'd1 >= h_eff) begin
              row_pos <= '0;
              row_ph  <= '0;
            end else begin
              row_pos <= row_pos + 1'b1;
              if (!rs_s[RowW+1]) row_ph <= (row_ph + 4'd1 == s_eff) ? 4'd0 : row_ph + 4'd1;
            end
          end else begin
            col_pos <= col_pos + 1'b1;
            if (!cs_s[RowW+1]) col_ph <= (col_ph + 4'd1 == s_eff) ? 4'd0 : col_ph + 4'd1;
          end
        end
        S_READ: begin
          if (emit_zero) begin
            sum <= '0; emit_last <= 1'b1;
            dcnt <= '0; state <= S_DIV; rem_q <= '0; quo <= '0; neg <= 1'b0;
          end else begin
            if (rd_pend) sum <= sum + SumW'(signed'(ram_rdata));
            if (wi == p_eff) begin
              state <= S_DIV;
              neg   <= sum[SumW-1] ^ 1'b0;
              quo   <= '0;
              rem_q <= '0;
              dcnt  <= '0;
            end else begin
              rd_pend <= 1'b1;
              if (wj + 5'd1 == p_eff) begin
                wj <= '0; wi <= wi + 5'd1;
              end else wj <= wj + 5'd1;
            end
          end
        end
        S_DIV: begin
          if (dcnt == 5'd0) begin
            neg  <= sum[SumW-1];
            quo  <= sum[SumW-1] ? SumW'(-sum) : SumW'(sum);
            rem_q <= '0;
            dcnt <= 5'd1;
          end else if (dcnt <= 5'(SumW)) begin
            if (!trial[SumW]) begin
              rem_q <= trial[SumW-1:0];
              quo   <= {quo[SumW-2:0], 1'b1};
            end else begin
              rem_q <= {rem_q[SumW-2:0], quo[SumW-1]};
              quo   <= {quo[SumW-2:0], 1'b0};
            end
            dcnt <= dcnt + 5'd1;
          end else state <= S_OUT;
        end
        S_OUT: begin
          // hold the new result until the output register is free
          if (!result_valid || result_ready) begin
            result_valid    <= 1'b1;
            average         <= neg ? 16'(-quo) : 16'(quo);
            last_of_channel <= emit_last;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
